[sv/ptc_pkg.sv]
// Types, constants and helper functions shared by the compensation pipeline.
`timescale 1ns / 1ps
package ptc_pkg;

    localparam int unsigned DivSteps = 32;

    localparam logic [1:0] CFG_TEMP_CAL       = 2'd0;
    localparam logic [1:0] CFG_PRESS_CAL_LOW  = 2'd1;
    localparam logic [1:0] CFG_PRESS_CAL_HIGH = 2'd2;
    localparam logic [1:0] CFG_PRESS_CAL_LAST = 2'd3;

    localparam logic [31:0] PRESS_OFFSET = 32'd64000;
    localparam logic [31:0] RAW_FULL     = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE  = 32'd3125;
    localparam logic [31:0] UNITY_Q15    = 32'd32768;
    localparam logic [31:0] ROUND_HALF   = 32'd128;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic [31:0]        press_pascal;
        logic               press_error;
    } out_item_t;

    // Calibration words as stored.
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } cal_t;

    // Side data that rides along the divider.
    typedef struct packed {
        logic [31:0] temp;
        logic        err;
        logic        dbl;
    } div_side_t;

    function automatic logic [31:0] asr(input logic [31:0] a, input int unsigned s);
        logic signed [31:0] v;
        v = $signed(a) >>> s;
        return v;
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

endpackage

[sv/pressure_temperature_compensation_unit.sv]
// Top level of the pressure and temperature compensation pipeline.
`timescale 1ns / 1ps
// Takes one raw temperature / raw pressure item per cycle and returns the
// compensated temperature (0.01 degC) and pressure (Pa) through 10 stages of
// calibration arithmetic, a 32-stage divider that resolves one quotient bit
// per stage, and 3 stages of final correction ending in the output register.
// Throughput is one item per cycle while not stalled. The whole pipeline
// advances together; it holds only while the output register carries an item
// that the downstream side stalls, and in_stall reflects exactly that. A zero
// divisor yields press_pascal 0 with press_error set; temperature is still
// valid. Write calibration through cfg_we/cfg_index/cfg_data only while no
// item is in flight; all arithmetic wraps at 32 bits.
module pressure_temperature_compensation_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ptc_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ptc_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    logic [47:0] temp_cal_reg;
    logic [63:0] press_low_reg, press_high_reg;
    logic [15:0] press_last_reg;
    ptc_pkg::cal_t cal;

    logic               adv;
    logic               f_valid, d_valid;
    logic [31:0]        f_num, f_den, d_quo;
    ptc_pkg::div_side_t f_side, d_side;

    // Advance unless a finished item is held at the output.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Calibration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg   <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_last_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptc_pkg::CFG_TEMP_CAL:       temp_cal_reg   <= cfg_data[47:0];
                ptc_pkg::CFG_PRESS_CAL_LOW:  press_low_reg  <= cfg_data;
                ptc_pkg::CFG_PRESS_CAL_HIGH: press_high_reg <= cfg_data;
                ptc_pkg::CFG_PRESS_CAL_LAST: press_last_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Unpack the calibration words.
    assign cal.t1 = temp_cal_reg[15:0];
    assign cal.t2 = temp_cal_reg[31:16];
    assign cal.t3 = temp_cal_reg[47:32];
    assign cal.p1 = press_low_reg[15:0];
    assign cal.p2 = press_low_reg[31:16];
    assign cal.p3 = press_low_reg[47:32];
    assign cal.p4 = press_low_reg[63:48];
    assign cal.p5 = press_high_reg[15:0];
    assign cal.p6 = press_high_reg[31:16];
    assign cal.p7 = press_high_reg[47:32];
    assign cal.p8 = press_high_reg[63:48];
    assign cal.p9 = press_last_reg;

    ptc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .cal       (cal),
        .div_valid (f_valid),
        .div_num   (f_num),
        .div_den   (f_den),
        .div_side  (f_side)
    );

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .in_side   (f_side),
        .out_valid (d_valid),
        .quo       (d_quo),
        .out_side  (d_side)
    );

    ptc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_valid),
        .quo       (d_quo),
        .in_side   (d_side),
        .cal       (cal),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // Input is held back only by a blocked output item.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked output item");

    // A zero divisor always reports zero pressure.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.press_error) |-> (out_data.press_pascal == 32'd0))
        else $error("error item carries nonzero pressure");

    // A frozen pipeline keeps its output item.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> (out_valid && $stable(out_data)))
        else $error("output item changed while pipeline frozen");
endmodule

[sv/ptc_front.sv]
// Temperature path and pressure divisor/dividend stages ahead of the divider.
`timescale 1ns / 1ps
module ptc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  ptc_pkg::in_item_t   in_data,
    input  ptc_pkg::cal_t       cal,
    output logic                div_valid,
    output logic [31:0]         div_num,
    output logic [31:0]         div_den,
    output ptc_pkg::div_side_t  div_side
);
    logic [9:0]  v_reg;
    logic [31:0] x1_reg, d1_reg, m1_reg, dd_reg, a3_reg, e3_reg, fine4_reg;
    logic [31:0] pa5_reg, q6_reg, m56_reg, m26_reg, b17_reg, m37_reg, m57_reg, m27_reg;
    logic [31:0] b8_reg, a8_reg, div9_reg, pre9_reg, div10_reg, p10_reg;
    logic [31:0] temp5_reg, temp6_reg, temp7_reg, temp8_reg, temp9_reg, temp10_reg;
    logic [19:0] ap1_reg, ap2_reg, ap3_reg, ap4_reg, ap5_reg, ap6_reg, ap7_reg, ap8_reg;
    logic [31:0] t1, a4, fine5;

    assign t1 = {16'd0, cal.t1};
    assign a4 = ptc_pkg::asr(pa5_reg, 2);
    assign fine5 = 32'({fine4_reg, 2'b00} + fine4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[8:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: raw offsets
            x1_reg  <= 32'({12'd0, in_data.raw_temp[19:3]}) - 32'({t1[30:0], 1'b0});
            d1_reg  <= 32'({12'd0, in_data.raw_temp[19:4]}) - t1;
            ap1_reg <= in_data.raw_press;
            // stage 2
            m1_reg  <= 32'(x1_reg * ptc_pkg::sx16(cal.t2));
            dd_reg  <= 32'(d1_reg * d1_reg);
            ap2_reg <= ap1_reg;
            // stage 3
            a3_reg  <= ptc_pkg::asr(m1_reg, 11);
            e3_reg  <= 32'(ptc_pkg::asr(dd_reg, 12) * ptc_pkg::sx16(cal.t3));
            ap3_reg <= ap2_reg;
            // stage 4: fine temperature
            fine4_reg <= a3_reg + ptc_pkg::asr(e3_reg, 14);
            ap4_reg   <= ap3_reg;
            // stage 5
            temp5_reg <= ptc_pkg::asr(fine5 + ptc_pkg::ROUND_HALF, 8);
            pa5_reg   <= ptc_pkg::asr(fine4_reg, 1) - ptc_pkg::PRESS_OFFSET;
            ap5_reg   <= ap4_reg;
            // stage 6
            q6_reg    <= 32'(a4 * a4);
            m56_reg   <= 32'(pa5_reg * ptc_pkg::sx16(cal.p5));
            m26_reg   <= 32'(ptc_pkg::sx16(cal.p2) * pa5_reg);
            temp6_reg <= temp5_reg;
            ap6_reg   <= ap5_reg;
            // stage 7
            b17_reg   <= 32'(ptc_pkg::asr(q6_reg, 11) * ptc_pkg::sx16(cal.p6));
            m37_reg   <= 32'(ptc_pkg::sx16(cal.p3) * ptc_pkg::asr(q6_reg, 13));
            m57_reg   <= m56_reg;
            m27_reg   <= m26_reg;
            temp7_reg <= temp6_reg;
            ap7_reg   <= ap6_reg;
            // stage 8
            b8_reg    <= ptc_pkg::asr(b17_reg + {m57_reg[30:0], 1'b0}, 2)
                         + {cal.p4, 16'd0};
            a8_reg    <= ptc_pkg::UNITY_Q15 + ptc_pkg::asr(ptc_pkg::asr(m37_reg, 3)
                         + ptc_pkg::asr(m27_reg, 1), 18);
            temp8_reg <= temp7_reg;
            ap8_reg   <= ap7_reg;
            // stage 9: divisor and offset pressure
            div9_reg  <= ptc_pkg::asr(32'(a8_reg * {16'd0, cal.p1}), 15);
            pre9_reg  <= (ptc_pkg::RAW_FULL - {12'd0, ap8_reg}) - ptc_pkg::asr(b8_reg, 12);
            temp9_reg <= temp8_reg;
            // stage 10
            p10_reg    <= 32'(pre9_reg * ptc_pkg::PRESS_SCALE);
            div10_reg  <= div9_reg;
            temp10_reg <= temp9_reg;
        end
    end

    assign div_valid     = v_reg[9];
    assign div_num       = p10_reg[31] ? p10_reg : {p10_reg[30:0], 1'b0};
    assign div_den       = div10_reg;
    assign div_side.temp = temp10_reg;
    assign div_side.err  = (div10_reg == 32'd0);
    assign div_side.dbl  = p10_reg[31];
endmodule

[sv/ptc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module ptc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [31:0]         num,
    input  logic [31:0]         den,
    input  ptc_pkg::div_side_t  in_side,
    output logic                out_valid,
    output logic [31:0]         quo,
    output ptc_pkg::div_side_t  out_side
);
    localparam int unsigned N = ptc_pkg::DivSteps;

    logic [31:0]        rem_reg  [N];
    logic [31:0]        nq_reg   [N];
    logic [31:0]        den_reg  [N];
    ptc_pkg::div_side_t side_reg [N];
    logic [N-1:0]       v_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [31:0]        rem_in, nq_in, den_in;
        ptc_pkg::div_side_t side_in;
        logic               v_in;
        logic [32:0]        sh;
        logic               ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign nq_in   = num;
            assign den_in  = den;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign nq_in   = nq_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        assign sh = {rem_in, nq_in[31]};
        assign ge = sh >= {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= ge ? 32'(sh - {1'b0, den_in}) : sh[31:0];
                nq_reg[k]   <= {nq_in[30:0], ge};
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign quo       = nq_reg[N-1];
    assign out_side  = side_reg[N-1];
endmodule

[sv/ptc_back.sv]
// Final pressure correction stages and output register.
`timescale 1ns / 1ps
module ptc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [31:0]         quo,
    input  ptc_pkg::div_side_t  in_side,
    input  ptc_pkg::cal_t       cal,
    output logic                out_valid,
    output ptc_pkg::out_item_t  out_data
);
    logic [2:0]  v_reg;
    logic [31:0] pfix, p1_reg, qq1_reg, m81_reg, p2_reg, ma2_reg, bb2_reg;
    logic [31:0] temp1_reg, temp2_reg;
    logic        err1_reg, err2_reg;
    logic [31:0] qa;
    ptc_pkg::out_item_t res_reg;

    assign pfix = in_side.dbl ? {quo[30:0], 1'b0} : quo;
    assign qa   = qq1_reg >> 13;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg    <= pfix;
            qq1_reg   <= 32'({3'd0, pfix[31:3]} * {3'd0, pfix[31:3]});
            m81_reg   <= 32'({2'd0, pfix[31:2]} * ptc_pkg::sx16(cal.p8));
            temp1_reg <= in_side.temp;
            err1_reg  <= in_side.err;

            p2_reg    <= p1_reg;
            ma2_reg   <= ptc_pkg::asr(32'(ptc_pkg::sx16(cal.p9) * qa), 12);
            bb2_reg   <= ptc_pkg::asr(m81_reg, 13);
            temp2_reg <= temp1_reg;
            err2_reg  <= err1_reg;

            res_reg.temp_centi   <= temp2_reg;
            res_reg.press_error  <= err2_reg;
            res_reg.press_pascal <= err2_reg ? 32'd0 : p2_reg
                + ptc_pkg::asr(ma2_reg + bb2_reg + ptc_pkg::sx16(cal.p7), 4);
        end
    end

    assign out_valid = v_reg[2];
    assign out_data  = res_reg;
endmodule

[tb/ptc_checker.sv]
// Checker for the compensation unit: tracks calibration, predicts results and compares them.
`timescale 1ns / 1ps
module ptc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  ptc_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  ptc_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import ptc_pkg::*;

    logic [47:0] temp_cal;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] press_last;
    out_item_t   comp_queue[$];

    assign pending = comp_queue.size();

    function automatic logic [31:0] sra(input logic [31:0] a, input int s);
        return $signed(a) >>> s;
    endfunction

    function automatic logic [31:0] ext(input logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    function automatic out_item_t compensate(input in_item_t it);
        out_item_t r;
        logic [31:0] adt, adp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, d, fine, q, p;
        adt = {12'd0, it.raw_temp};
        adp = {12'd0, it.raw_press};
        t1 = {16'd0, temp_cal[15:0]};
        t2 = ext(temp_cal[31:16]);
        t3 = ext(temp_cal[47:32]);
        p1 = {16'd0, press_lo[15:0]};
        p2 = ext(press_lo[31:16]);
        p3 = ext(press_lo[47:32]);
        p4 = ext(press_lo[63:48]);
        p5 = ext(press_hi[15:0]);
        p6 = ext(press_hi[31:16]);
        p7 = ext(press_hi[47:32]);
        p8 = ext(press_hi[63:48]);
        p9 = ext(press_last);
        a = sra(((adt >> 3) - (t1 << 1)) * t2, 11);
        d = (adt >> 4) - t1;
        b = sra(sra(d * d, 12) * t3, 14);
        fine = a + b;
        r.temp_centi = sra(fine * 32'd5 + 32'd128, 8);
        a = sra(fine, 1) - 32'd64000;
        q = sra(a, 2) * sra(a, 2);
        b = sra(q, 11) * p6;
        b = b + ((a * p5) << 1);
        b = sra(b, 2) + (p4 << 16);
        a = sra(sra(p3 * sra(q, 13), 3) + sra(p2 * a, 1), 18);
        a = sra((32'd32768 + a) * p1, 15);
        if (a == 32'd0)
        begin
            r.press_pascal = '0;
            r.press_error  = 1'b1;
            return r;
        end
        p = ((32'd1048576 - adp) - sra(b, 12)) * 32'd3125;
        if (!p[31])
            p = (p << 1) / a;
        else
            p = (p / a) * 32'd2;
        q = ((p >> 3) * (p >> 3)) >> 13;
        a = sra(p9 * q, 12);
        b = sra((p >> 2) * p8, 13);
        r.press_pascal = p + sra(a + b + p7, 4);
        r.press_error  = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            temp_cal   <= '0;
            press_lo   <= '0;
            press_hi   <= '0;
            press_last <= '0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TEMP_CAL:       temp_cal   <= cfg_data[47:0];
                    CFG_PRESS_CAL_LOW:  press_lo   <= cfg_data;
                    CFG_PRESS_CAL_HIGH: press_hi   <= cfg_data;
                    CFG_PRESS_CAL_LAST: press_last <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                comp_queue.push_back(compensate(in_data));
            if (out_valid && !out_stall)
            begin
                if (comp_queue.size() == 0)
                begin
                    $error("unexpected item: temp_centi %0d", out_data.temp_centi);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = comp_queue.pop_front();
                    if (want.temp_centi !== out_data.temp_centi)
                    begin
                        $error("temp_centi: expected %0d, got %0d",
                               want.temp_centi, out_data.temp_centi);
                        fail_count <= fail_count + 1;
                    end
                    else if (want.press_pascal !== out_data.press_pascal)
                    begin
                        $error("press_pascal: expected %0d, got %0d",
                               want.press_pascal, out_data.press_pascal);
                        fail_count <= fail_count + 1;
                    end
                    else if (want.press_error !== out_data.press_error)
                    begin
                        $error("press_error: expected %0b, got %0b",
                               want.press_error, out_data.press_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/tb.sv]
// Testbench top: clock, reset, calibration phases, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
    import ptc_pkg::*;

    localparam int PipeDepth  = 45;
    localparam int CycleLimit = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          send_idle;   // percent of cycles the sender holds off
    int          recv_stall;  // percent of cycles the receiver stalls

    pressure_temperature_compensation_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ptc_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung pipeline ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver stall runs on its own, redrawn every cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(99, 0) < recv_stall);

    // Drive one item; hold it until the block takes it. Drop the write
    // enable left by a preceding calibration write.
    task automatic send_item(input logic [19:0] rt, input logic [19:0] rp);
        cfg_we <= 1'b0;
        while ($urandom_range(99, 0) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{raw_temp: rt, raw_press: rp};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid, drain everything in flight, then give the pipeline its full depth.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (PipeDepth + 4) @(posedge clk);
    endtask

    task automatic write_cal(input logic [1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Calibration typical of a real sensor, with random jitter on every word.
    task automatic write_typical_cal();
        write_cal(CFG_TEMP_CAL, 64'({16'(-$urandom_range(1200, 0)),
                                     16'(26000 + $urandom_range(2000, 0)),
                                     16'(27000 + $urandom_range(2000, 0))}));
        write_cal(CFG_PRESS_CAL_LOW, {16'(2000 + $urandom_range(5000, 0)),
                                      16'(4000 + $urandom_range(1000, 0)),
                                      16'(-10500 - $urandom_range(500, 0)),
                                      16'(36000 + $urandom_range(2000, 0))});
        write_cal(CFG_PRESS_CAL_HIGH, {16'(-$urandom_range(20000, 0)),
                                       16'(15000 + $urandom_range(1000, 0)),
                                       16'(-$urandom_range(100, 0)),
                                       16'($urandom_range(300, 0))});
        write_cal(CFG_PRESS_CAL_LAST, 64'(6000 + $urandom_range(500, 0)));
    endtask

    task automatic write_random_cal();
        write_cal(CFG_TEMP_CAL, {$urandom, $urandom});
        write_cal(CFG_PRESS_CAL_LOW, {$urandom, $urandom});
        write_cal(CFG_PRESS_CAL_HIGH, {$urandom, $urandom});
        write_cal(CFG_PRESS_CAL_LAST, {$urandom, $urandom});
    endtask

    // Random items: mostly realistic readings, some full-range noise.
    task automatic send_random(input int count);
        repeat (count)
        begin
            if ($urandom_range(3, 0) != 0)
                send_item(20'($urandom_range(560000, 480000)),
                          20'($urandom_range(450000, 250000)));
            else
                send_item(20'($urandom), 20'($urandom));
        end
    endtask

    initial
    begin
        cycle_count = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_TEMP_CAL;
        cfg_data    = '0;
        send_idle   = 0;
        recv_stall  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: P1 is zero, so every item hits the zero divisor.
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        drain();

        // Directed: field extremes with typical calibration.
        write_typical_cal();
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'h00000, 20'hFFFFF);
        send_item(20'hFFFFF, 20'h00000);
        send_item(20'd519888, 20'd415148);
        send_item(20'h55555, 20'hAAAAA);
        send_item(20'hAAAAA, 20'h55555);
        drain();

        // Extreme calibration: all ones, then a mix of most positive and most negative words.
        write_cal(CFG_TEMP_CAL, {64{1'b1}});
        write_cal(CFG_PRESS_CAL_LOW, {64{1'b1}});
        write_cal(CFG_PRESS_CAL_HIGH, {64{1'b1}});
        write_cal(CFG_PRESS_CAL_LAST, {64{1'b1}});
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'd519888, 20'd415148);
        drain();
        write_cal(CFG_TEMP_CAL, 64'({16'h7FFF, 16'h7FFF, 16'hFFFF}));
        write_cal(CFG_PRESS_CAL_LOW, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
        write_cal(CFG_PRESS_CAL_HIGH, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        write_cal(CFG_PRESS_CAL_LAST, 64'h8000);
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'h80000, 20'h80000);
        drain();

        // Random phases under each idling pattern, fresh calibration each time.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 82;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 82;
                end
                default:
                begin
                    send_idle  = 28;
                    recv_stall = 28;
                end
            endcase
            if (ph == 3 || ph == 7)
                write_random_cal();
            else
                write_typical_cal();
            send_random(200);
            drain();
        end

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
